// ----- design/priority_timer_scheduler_defines.svh -----
// Assertion macros used by the checker of the timer scheduler.
`ifndef PRIORITY_TIMER_SCHEDULER_DEFINES_SVH
`define PRIORITY_TIMER_SCHEDULER_DEFINES_SVH

// Antecedent at one edge, consequent at the next edge.
`define PTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer scheduler check failed");

// Antecedent and consequent at the same edge.
`define PTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer scheduler check failed");

`endif

// ----- design/pts_pkg.sv -----
`default_nettype none

package pts_pkg;

    localparam int OP_W         = 2;
    localparam int SLOT_W       = 4;
    localparam int DELAY_W      = 32;
    localparam int PRIO_W       = 3;
    localparam int NOW_W        = 48;
    localparam int US_PER_MS    = 1000;
    localparam int US_PER_MS_W  = 10;
    localparam int PRIO_CLASSES = 5;

    // last class scanned with and without pending events
    localparam logic [PRIO_W-1:0] CLS_LAST_PEND = 3'd2;
    localparam logic [PRIO_W-1:0] CLS_LAST_ALL  = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_ARM    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic idle;
        logic rd;
        logic eval;
        logic commit;
        logic advance;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tick_req;
        logic skip;
        logic fire;
        logic hold_valid;
        logic out_free;
        logic scan_last;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- design/pts_req_if.sv -----
`default_nettype none

interface pts_req_if;
    logic                            valid;
    logic                            ready;
    logic [pts_pkg::OP_W-1:0]        operation;
    logic [pts_pkg::SLOT_W-1:0]      slot;
    logic [pts_pkg::DELAY_W-1:0]     delay_ms;
    logic [pts_pkg::PRIO_W-1:0]      priority_req;
    logic                            repeating;
    logic [pts_pkg::NOW_W-1:0]       now_us;
    logic                            events_pending;

    modport source (output valid, operation, slot, delay_ms, priority_req, repeating,
                    now_us, events_pending, input ready);
    modport sink   (input valid, operation, slot, delay_ms, priority_req, repeating,
                    now_us, events_pending, output ready);
    modport monitor (input valid, ready, operation, slot, delay_ms, priority_req,
                     repeating, now_us, events_pending);
endinterface

`default_nettype wire

// ----- design/pts_rsp_if.sv -----
`default_nettype none

interface pts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [pts_pkg::SLOT_W-1:0]  fired_slot;
    logic [pts_pkg::PRIO_W-1:0]  fired_priority;
    logic                        fired_repeats;
    logic                        last;

    modport source (output valid, fired_slot, fired_priority, fired_repeats, last,
                    input ready);
    modport sink   (input valid, fired_slot, fired_priority, fired_repeats, last,
                    output ready);
    modport monitor (input valid, ready, fired_slot, fired_priority, fired_repeats, last);
endinterface

`default_nettype wire

// ----- design/pts_ram.sv -----
`default_nettype none

module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/pts_ctrl.sv -----
`default_nettype none

module pts_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pts_pkg::ctrl_sts_t sts,
    output pts_pkg::ctrl_cmd_t      cmd
);

    pts_pkg::state_t state_reg;
    pts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                if (sts.tick_req)
                begin
                    state_next = pts_pkg::ST_READ;
                end
            end
            pts_pkg::ST_READ:
            begin
                if (!sts.skip)
                begin
                    state_next = pts_pkg::ST_EVAL;
                end
                else if (sts.scan_last)
                begin
                    state_next = pts_pkg::ST_FLUSH;
                end
            end
            pts_pkg::ST_EVAL:
            begin
                state_next = pts_pkg::ST_DECIDE;
            end
            pts_pkg::ST_DECIDE:
            begin
                if (!(sts.fire && sts.hold_valid && !sts.out_free))
                begin
                    state_next = sts.scan_last ? pts_pkg::ST_FLUSH : pts_pkg::ST_READ;
                end
            end
            pts_pkg::ST_FLUSH:
            begin
                if (!sts.hold_valid || sts.out_free)
                begin
                    state_next = pts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            pts_pkg::ST_IDLE:
            begin
                cmd.idle = 1'b1;
            end
            pts_pkg::ST_READ:
            begin
                cmd.rd      = 1'b1;
                cmd.advance = sts.skip;
            end
            pts_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            pts_pkg::ST_DECIDE:
            begin
                if (!(sts.fire && sts.hold_valid && !sts.out_free))
                begin
                    cmd.commit  = 1'b1;
                    cmd.advance = 1'b1;
                end
            end
            pts_pkg::ST_FLUSH:
            begin
                cmd.flush = sts.hold_valid && sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/pts_datapath.sv -----
`default_nettype none

module pts_datapath #(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_BITS   = 48
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    pts_req_if.sink                 req,
    pts_rsp_if.source               rsp,
    input  wire pts_pkg::ctrl_cmd_t cmd,
    output pts_pkg::ctrl_sts_t      sts
);

    localparam int IDX_W  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int SPAN_W = pts_pkg::DELAY_W + pts_pkg::US_PER_MS_W;
    localparam int CMP_W  = (TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W;
    localparam int CFG_W  = pts_pkg::DELAY_W + pts_pkg::PRIO_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

    logic [TIMER_SLOTS-1:0]          armed_reg, armed_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [pts_pkg::PRIO_W-1:0]      cls_reg, cls_next;
    logic [TIME_BITS-1:0]            now_reg, now_next;
    logic                            pend_reg, pend_next;
    logic [SPAN_W-1:0]               span_reg, span_next;
    logic [TIME_BITS-1:0]            diff_reg, diff_next;
    logic                            started_reg, started_next;
    logic                            match_reg, match_next;
    logic                            rep_reg, rep_next;
    logic                            hold_valid_reg, hold_valid_next;
    logic [pts_pkg::SLOT_W-1:0]      hold_slot_reg, hold_slot_next;
    logic [pts_pkg::PRIO_W-1:0]      hold_prio_reg, hold_prio_next;
    logic                            hold_rep_reg, hold_rep_next;
    logic                            out_valid_reg, out_valid_next;
    logic [pts_pkg::SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [pts_pkg::PRIO_W-1:0]      out_prio_reg, out_prio_next;
    logic                            out_rep_reg, out_rep_next;
    logic                            out_last_reg, out_last_next;

    logic                            take;
    logic                            arm_ok;
    logic                            cancel_ok;
    logic                            slot_ok;
    logic [IDX_W-1:0]                slot_idx;
    logic [TIME_BITS-1:0]            req_now;
    logic                            fire;
    logic                            out_free;
    logic                            scan_last;
    logic                            restart;

    logic                            start_we;
    logic [IDX_W-1:0]                start_waddr;
    logic [TIME_BITS-1:0]            start_wdata;
    logic [TIME_BITS-1:0]            start_rdata;
    logic [CFG_W-1:0]                cfg_rdata;
    logic [pts_pkg::DELAY_W-1:0]     rd_delay;
    logic [pts_pkg::PRIO_W-1:0]      rd_prio;
    logic                            rd_rep;

    assign take      = cmd.idle && req.valid;
    assign slot_ok   = int'(req.slot) < TIMER_SLOTS;
    assign slot_idx  = IDX_W'(req.slot);
    assign req_now   = TIME_BITS'(req.now_us);
    assign arm_ok    = take && (req.operation == pts_pkg::OP_ARM) && slot_ok &&
                       (req.priority_req < pts_pkg::PRIO_W'(pts_pkg::PRIO_CLASSES));
    assign cancel_ok = take && (req.operation == pts_pkg::OP_CANCEL) && slot_ok;

    assign {rd_delay, rd_prio, rd_rep} = cfg_rdata;

    assign fire      = armed_reg[idx_reg] && match_reg && started_reg &&
                       (CMP_W'(diff_reg) >= CMP_W'(span_reg));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign scan_last = (idx_reg == LAST_IDX) &&
                       (cls_reg == (pend_reg ? pts_pkg::CLS_LAST_PEND : pts_pkg::CLS_LAST_ALL));
    assign restart   = cmd.commit && fire && rep_reg;

    assign start_we    = arm_ok || restart;
    assign start_waddr = cmd.idle ? slot_idx : idx_reg;
    assign start_wdata = cmd.idle ? req_now : now_reg;

    pts_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (TIMER_SLOTS)
    ) u_start_ram (
        .clk   (clk),
        .we    (start_we),
        .waddr (start_waddr),
        .wdata (start_wdata),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (start_rdata)
    );

    pts_ram #(
        .WIDTH (CFG_W),
        .DEPTH (TIMER_SLOTS)
    ) u_cfg_ram (
        .clk   (clk),
        .we    (arm_ok),
        .waddr (slot_idx),
        .wdata ({req.delay_ms, req.priority_req, req.repeating}),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (cfg_rdata)
    );

    always_comb
    begin
        armed_next      = armed_reg;
        idx_next        = idx_reg;
        cls_next        = cls_reg;
        now_next        = now_reg;
        pend_next       = pend_reg;
        span_next       = span_reg;
        diff_next       = diff_reg;
        started_next    = started_reg;
        match_next      = match_reg;
        rep_next        = rep_reg;
        hold_valid_next = hold_valid_reg;
        hold_slot_next  = hold_slot_reg;
        hold_prio_next  = hold_prio_reg;
        hold_rep_next   = hold_rep_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_slot_next   = out_slot_reg;
        out_prio_next   = out_prio_reg;
        out_rep_next    = out_rep_reg;
        out_last_next   = out_last_reg;

        if (arm_ok)
        begin
            armed_next[slot_idx] = 1'b1;
        end
        if (cancel_ok)
        begin
            armed_next[slot_idx] = 1'b0;
        end

        if (take && (req.operation == pts_pkg::OP_TICK))
        begin
            idx_next  = '0;
            cls_next  = '0;
            now_next  = req_now;
            pend_next = req.events_pending;
        end

        if (cmd.eval)
        begin
            span_next    = SPAN_W'(rd_delay) * SPAN_W'(pts_pkg::US_PER_MS);
            diff_next    = now_reg - start_rdata;
            started_next = now_reg >= start_rdata;
            match_next   = rd_prio == cls_reg;
            rep_next     = rd_rep;
        end

        if (cmd.commit && fire)
        begin
            if (!rep_reg)
            begin
                armed_next[idx_reg] = 1'b0;
            end
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_slot_next  = hold_slot_reg;
                out_prio_next  = hold_prio_reg;
                out_rep_next   = hold_rep_reg;
                out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_slot_next  = pts_pkg::SLOT_W'(idx_reg);
            hold_prio_next  = cls_reg;
            hold_rep_next   = rep_reg;
        end

        if (cmd.advance)
        begin
            if (idx_reg == LAST_IDX)
            begin
                idx_next = '0;
                cls_next = cls_reg + 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmd.flush)
        begin
            out_valid_next  = 1'b1;
            out_slot_next   = hold_slot_reg;
            out_prio_next   = hold_prio_reg;
            out_rep_next    = hold_rep_reg;
            out_last_next   = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            armed_reg      <= armed_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cls_reg       <= cls_next;
        now_reg       <= now_next;
        pend_reg      <= pend_next;
        span_reg      <= span_next;
        diff_reg      <= diff_next;
        started_reg   <= started_next;
        match_reg     <= match_next;
        rep_reg       <= rep_next;
        hold_slot_reg <= hold_slot_next;
        hold_prio_reg <= hold_prio_next;
        hold_rep_reg  <= hold_rep_next;
        out_slot_reg  <= out_slot_next;
        out_prio_reg  <= out_prio_next;
        out_rep_reg   <= out_rep_next;
        out_last_reg  <= out_last_next;
    end

    assign req.ready          = cmd.idle;
    assign rsp.valid          = out_valid_reg;
    assign rsp.fired_slot     = out_slot_reg;
    assign rsp.fired_priority = out_prio_reg;
    assign rsp.fired_repeats  = out_rep_reg;
    assign rsp.last           = out_last_reg;

    assign sts.tick_req   = req.valid && (req.operation == pts_pkg::OP_TICK);
    assign sts.skip       = !armed_reg[idx_reg];
    assign sts.fire       = fire;
    assign sts.hold_valid = hold_valid_reg;
    assign sts.out_free   = out_free;
    assign sts.scan_last  = scan_last;

endmodule

`default_nettype wire

// ----- design/priority_timer_scheduler.sv -----
// Timer slot scheduler. Arm and cancel requests are taken in the idle state and do
// not leave it. A tick request walks the slot table once per priority class (five
// classes, three while events are pending), in ascending slot order; a free slot is
// skipped in the read step, while an armed slot goes through the RAM read,
// delay*1000 and elapsed time, and due check steps. A stalled result side holds the
// tick. One result is held back so the last one of a tick carries the last flag;
// arm, cancel and ticks with nothing due give no result. A result waiting in the
// output register does not block the next request.
`default_nettype none

module priority_timer_scheduler #(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_BITS   = 48
) (
    input  wire logic clk,
    input  wire logic rst_n,
    pts_req_if.sink   req,
    pts_rsp_if.source rsp
);

    pts_pkg::ctrl_cmd_t cmd;
    pts_pkg::ctrl_sts_t sts;

    pts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    pts_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule

`default_nettype wire

// ----- design/pts_checker.sv -----
`default_nettype none
`include "priority_timer_scheduler_defines.svh"

module pts_checker (
    input wire logic                                      clk,
    input wire logic                                      rst_n,
    input wire logic                                      req_valid,
    input wire logic                                      req_ready,
    input wire logic [pts_pkg::OP_W-1:0]                  req_operation,
    input wire logic                                      rsp_valid,
    input wire logic                                      rsp_ready,
    input wire logic [pts_pkg::SLOT_W+pts_pkg::PRIO_W:0]  rsp_payload,
    input wire logic                                      rsp_last
);

    logic req_take;
    logic req_tick;

    assign req_take = req_valid && req_ready;
    assign req_tick = req_operation == pts_pkg::OP_TICK;

    `PTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_payload, rsp_last}))
    `PTS_ASSERT_NEXT(a_tick_busy, req_take && req_tick, !req_ready)
    `PTS_ASSERT_NEXT(a_arm_cancel_quick, req_take && !req_tick, req_ready)
    `PTS_ASSERT_SAME(a_more_results_busy, rsp_valid && !rsp_last, !req_ready)

endmodule

bind priority_timer_scheduler pts_checker u_pts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_operation (req.operation),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_payload   ({rsp.fired_slot, rsp.fired_priority, rsp.fired_repeats}),
    .rsp_last      (rsp.last)
);

`default_nettype wire

// ----- tb/priority_timer_scheduler_tb.sv -----
`default_nettype none

module priority_timer_scheduler_tb;
    import pts_pkg::*;

    localparam int SLOTS = 16;
    localparam int RANDOM_REQUESTS = 250;
    localparam int SETTLE_CYCLES = 300;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [NOW_W-1:0] NOW_MAX = '1;
    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [SLOT_W-1:0]  slot;
        logic [DELAY_W-1:0] delay_ms;
        logic [PRIO_W-1:0]  prio;
        logic               repeating;
        logic [NOW_W-1:0]   now_us;
        logic               events_pending;
    } timer_req_t;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] prio;
        logic              repeats;
        logic              last;
    } firing_t;

    class timer_scoreboard;
        bit                 armed [SLOTS];
        logic [NOW_W-1:0]   start_us [SLOTS];
        logic [DELAY_W-1:0] delay_ms [SLOTS];
        logic [PRIO_W-1:0]  prio [SLOTS];
        bit                 repeats [SLOTS];
        firing_t            firing_q [$];
        int                 errors;

        function new();
            foreach (armed[s])
                armed[s] = 1'b0;
            errors = 0;
        endfunction

        function bit slot_due(int s, logic [NOW_W-1:0] now);
            logic [63:0] span;
            logic [63:0] elapsed;
            if (now < start_us[s])
                return 1'b0;
            span = 64'(delay_ms[s]) * 64'(US_PER_MS);
            elapsed = 64'(now) - 64'(start_us[s]);
            return elapsed >= span;
        endfunction

        function void note_request(timer_req_t r);
            logic [PRIO_W-1:0] top;
            firing_t f;
            int n;
            n = 0;
            if (r.op == OP_ARM)
            begin
                if (r.prio < PRIO_CLASSES)
                begin
                    armed[r.slot] = 1'b1;
                    start_us[r.slot] = r.now_us;
                    delay_ms[r.slot] = r.delay_ms;
                    prio[r.slot] = r.prio;
                    repeats[r.slot] = r.repeating;
                end
            end
            else if (r.op == OP_CANCEL)
                armed[r.slot] = 1'b0;
            else if (r.op == OP_TICK)
            begin
                top = r.events_pending ? CLS_LAST_PEND : CLS_LAST_ALL;
                for (int c = 0; c <= int'(top); c++)
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (armed[s] && prio[s] == c && slot_due(s, r.now_us))
                        begin
                            f.slot = SLOT_W'(s);
                            f.prio = PRIO_W'(c);
                            f.repeats = repeats[s];
                            f.last = 1'b0;
                            firing_q.push_back(f);
                            n++;
                            if (repeats[s])
                                start_us[s] = r.now_us;
                            else
                                armed[s] = 1'b0;
                        end
                    end
                end
                if (n > 0)
                    firing_q[firing_q.size()-1].last = 1'b1;
            end
        endfunction

        function void check_firing(firing_t got);
            firing_t want;
            if (firing_q.size() == 0)
            begin
                $error("unexpected firing: fired_slot %0d fired_priority %0d",
                       got.slot, got.prio);
                errors++;
                return;
            end
            want = firing_q.pop_front();
            if (got.slot !== want.slot)
            begin
                $error("fired_slot: expected %0d, got %0d", want.slot, got.slot);
                errors++;
            end
            if (got.prio !== want.prio)
            begin
                $error("fired_priority: expected %0d, got %0d", want.prio, got.prio);
                errors++;
            end
            if (got.repeats !== want.repeats)
            begin
                $error("fired_repeats: expected %0d, got %0d", want.repeats, got.repeats);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int outstanding();
            return firing_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pts_req_if req_ch();
    pts_rsp_if rsp_ch();

    priority_timer_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    timer_scoreboard sb;
    logic [NOW_W-1:0] clock_us;
    int sent;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("[priority_timer_scheduler] ERROR");
        $finish;
    end

    function automatic timer_req_t make_req(logic [OP_W-1:0] op, int slot,
                                            logic [DELAY_W-1:0] delay, int prio,
                                            bit rep, logic [NOW_W-1:0] now, bit pend);
        timer_req_t r;
        r.op = op;
        r.slot = SLOT_W'(slot);
        r.delay_ms = delay;
        r.prio = PRIO_W'(prio);
        r.repeating = rep;
        r.now_us = now;
        r.events_pending = pend;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 60)
            return 0;
        if (roll < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(15, 60));
    endfunction

    function automatic logic [NOW_W-1:0] random_time();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[NOW_W-1:0];
    endfunction

    task automatic send_request(timer_req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= r.op;
        req_ch.slot <= r.slot;
        req_ch.delay_ms <= r.delay_ms;
        req_ch.priority_req <= r.prio;
        req_ch.repeating <= r.repeating;
        req_ch.now_us <= r.now_us;
        req_ch.events_pending <= r.events_pending;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(r);
        if (!(r.op == OP_UNUSED || (r.op == OP_ARM && r.prio >= PRIO_CLASSES)))
            sent++;
    endtask

    task automatic drain_firings();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // result side back-pressure
    initial
    begin
        int stall;
        int roll;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            roll = int'($urandom_range(0, 99));
            if (roll < 70)
                stall = int'($urandom_range(1, 3));
            else if (roll < 95)
                stall = int'($urandom_range(4, 10));
            else
                stall = int'($urandom_range(20, 50));
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        firing_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.slot = rsp_ch.fired_slot;
            got.prio = rsp_ch.fired_priority;
            got.repeats = rsp_ch.fired_repeats;
            got.last = rsp_ch.last;
            sb.check_firing(got);
        end
    end

    initial
    begin
        timer_req_t r;
        int roll;
        sb = new();
        sent = 0;
        clock_us = '0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.operation <= OP_ARM;
        req_ch.slot <= '0;
        req_ch.delay_ms <= '0;
        req_ch.priority_req <= '0;
        req_ch.repeating <= 1'b0;
        req_ch.now_us <= '0;
        req_ch.events_pending <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_req(OP_TICK, 0, 0, 0, 0, 0, 0));
        send_request(make_req(OP_ARM, 0, 0, 0, 0, 0, 0));
        send_request(make_req(OP_ARM, 15, 1, 4, 1, 0, 0));
        send_request(make_req(OP_ARM, 3, 5, 5, 1, 0, 0));
        send_request(make_req(OP_ARM, 4, DELAY_MAX, 7, 0, NOW_MAX, 1));
        send_request(make_req(OP_CANCEL, 7, 0, 0, 0, 0, 0));
        send_request(make_req(OP_UNUSED, 15, DELAY_MAX, 7, 1, NOW_MAX, 1));
        send_request(make_req(OP_TICK, 0, 0, 0, 0, 500, 1));
        send_request(make_req(OP_TICK, 0, 0, 0, 0, 1000, 1));
        send_request(make_req(OP_TICK, 0, 0, 0, 0, 1000, 0));
        // rearm overwrites priority, delay and repeat
        send_request(make_req(OP_ARM, 15, 2, 2, 0, 5000, 0));
        send_request(make_req(OP_ARM, 9, 0, 3, 1, 100000, 0));
        send_request(make_req(OP_ARM, 8, DELAY_MAX, 1, 1, 0, 0));
        send_request(make_req(OP_TICK, 0, 0, 0, 0, 7000, 0));
        send_request(make_req(OP_CANCEL, 8, 0, 0, 0, 0, 0));
        send_request(make_req(OP_TICK, 0, 0, 0, 0, 48'd4294967295000, 1));
        send_request(make_req(OP_TICK, 0, 0, 0, 0, 48'd4294967295000, 0));
        send_request(make_req(OP_ARM, 1, 0, 0, 0, NOW_MAX, 0));
        send_request(make_req(OP_ARM, 2, DELAY_MAX, 1, 0, 0, 0));
        send_request(make_req(OP_TICK, 0, 0, 0, 0, NOW_MAX, 0));
        send_request(make_req(OP_CANCEL, 9, 0, 0, 0, 0, 0));
        drain_firings();

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            roll = int'($urandom_range(0, 99));
            if (roll < 30)
                send_request(make_req(OP_ARM, int'($urandom_range(0, SLOTS-1)),
                                      $urandom_range(0, 30),
                                      int'($urandom_range(0, PRIO_CLASSES-1)),
                                      1'($urandom_range(0, 1)), clock_us, 1'b0));
            else if (roll < 40)
                send_request(make_req(OP_CANCEL, int'($urandom_range(0, SLOTS-1)),
                                      0, 0, 0, 0, 0));
            else if (roll < 75)
            begin
                clock_us = clock_us + NOW_W'($urandom_range(0, 20000));
                send_request(make_req(OP_TICK, 0, 0, 0, 0, clock_us,
                                      1'($urandom_range(0, 1))));
            end
            else if (roll < 80)
            begin
                // fill every slot, then one tick fires them all
                for (int s = 0; s < SLOTS; s++)
                    send_request(make_req(OP_ARM, s, $urandom_range(0, 2),
                                          int'($urandom_range(0, PRIO_CLASSES-1)),
                                          1'($urandom_range(0, 1)), clock_us, 1'b0));
                clock_us = clock_us + NOW_W'(3000);
                send_request(make_req(OP_TICK, 0, 0, 0, 0, clock_us, 0));
            end
            else if (roll < 84)
                drain_firings();
            else
            begin
                r.op = OP_W'($urandom_range(0, 3));
                r.slot = SLOT_W'($urandom_range(0, SLOTS-1));
                r.delay_ms = $urandom;
                r.prio = PRIO_W'($urandom_range(0, 7));
                r.repeating = 1'($urandom_range(0, 1));
                r.now_us = random_time();
                r.events_pending = 1'($urandom_range(0, 1));
                send_request(r);
            end
        end

        req_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("[priority_timer_scheduler] OK");
        else
            $display("[priority_timer_scheduler] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
